// ===== sv/urm_pkg.sv =====
// Package for the median-of-three ultrasonic ranger.
// Holds payload and config structs, phase codes, constants and the median function.
// No dependencies.
package urm_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int US_W            = 16;
    localparam int MM_W            = 14;
    localparam int SAMPLE_W        = US_W + 1;
    localparam int NUM_SAMPLES     = 3;
    localparam int PROD_W          = 30;

    localparam logic [MM_W-1:0] MM_SCALE = 14'd11141;

    // Register indexes of the config port
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_TIMEOUT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_GAP   = 2'd3;

    // Register reset values
    localparam logic [7:0]  TRIGGER_LOW_RST  = 8'd2;
    localparam logic [7:0]  TRIGGER_HIGH_RST = 8'd12;
    localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd30000;
    localparam logic [15:0] SAMPLE_GAP_RST   = 16'd10000;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_WAIT  = 3'd3,
        PH_ECHO  = 3'd4,
        PH_GAP   = 3'd5
    } t_phase;

    typedef struct packed {
        logic echo_level;
        logic start_request;
    } t_in;

    typedef struct packed {
        logic            trigger_level;
        logic            busy_res;
        logic            result_valid;
        logic            echo_found;
        logic [US_W-1:0] median_echo_us;
        logic [MM_W-1:0] distance_mm;
    } t_out;

    typedef struct packed {
        logic [7:0]  trigger_low_us;
        logic [7:0]  trigger_high_us;
        logic [15:0] echo_timeout_us;
        logic [15:0] sample_gap_us;
    } t_cfg;

    // Median of three samples; bit 16 marks an infinite sample, so it sorts last
    function automatic logic [SAMPLE_W-1:0] median3(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b,
                                                    input logic [SAMPLE_W-1:0] c);
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

// ===== sv/urm_cfg.sv =====
// Configuration registers of the ranger: trigger timing, echo timeout, gap.
// Depends on urm_pkg.
module urm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [urm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [urm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output urm_pkg::t_cfg                   o_cfg
);
    import urm_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register, keeping its low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_low_us  <= TRIGGER_LOW_RST;
            r_cfg.trigger_high_us <= TRIGGER_HIGH_RST;
            r_cfg.echo_timeout_us <= ECHO_TIMEOUT_RST;
            r_cfg.sample_gap_us   <= SAMPLE_GAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIGGER_LOW:  r_cfg.trigger_low_us  <= i_cfg_data[7:0];
                CFG_TRIGGER_HIGH: r_cfg.trigger_high_us <= i_cfg_data[7:0];
                CFG_ECHO_TIMEOUT: r_cfg.echo_timeout_us <= i_cfg_data;
                CFG_SAMPLE_GAP:   r_cfg.sample_gap_us   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/urm_ctrl.sv =====
// Ranging sequencer: phase, tick counter, sample store and median report.
// One call of the step logic per enabled tick. Depends on urm_pkg.
module urm_ctrl #(
    parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  urm_pkg::t_in  i_in,
    input  urm_pkg::t_cfg i_cfg,
    output urm_pkg::t_out o_res
);
    import urm_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int LW = (CW > 16) ? CW : 16;
    localparam logic [CW-1:0] CMAX = '1;

    t_phase              r_phase, n_phase;
    logic [CW-1:0]       r_tc, n_tc;
    logic [1:0]          r_si, n_si;
    logic [SAMPLE_W-1:0] r_samples [NUM_SAMPLES];

    logic                wr_en;
    logic [1:0]          wr_idx;
    logic [SAMPLE_W-1:0] wr_data;
    logic [SAMPLE_W-1:0] view [NUM_SAMPLES];
    logic [CW-1:0]       bumped;
    logic [CW-1:0]       lim_to;
    logic                gap_done;
    logic [2:0]          si_sum;
    logic [SAMPLE_W-1:0] med;
    logic [PROD_W-1:0]   prod;
    t_out                res;

    // Clamp a limit to at least one and at most the counter maximum
    function automatic logic [CW-1:0] lim(input logic [15:0] v);
        logic [LW-1:0] ve;
        ve = LW'(v);
        if (ve == '0) ve = LW'(1);
        if (ve > LW'(CMAX)) ve = LW'(CMAX);
        return ve[CW-1:0];
    endfunction

    // Saturating increment of the tick counter
    function automatic logic [CW-1:0] bump(input logic [CW-1:0] t);
        return (t == CMAX) ? t : t + CW'(1);
    endfunction

    assign wr_idx = (r_si < 2'd3) ? r_si : 2'd0;
    assign lim_to = lim(i_cfg.echo_timeout_us);

    // Step logic for one tick
    always_comb begin
        n_phase  = r_phase;
        n_tc     = r_tc;
        n_si     = r_si;
        wr_en    = 1'b0;
        wr_data  = '0;
        bumped   = '0;
        gap_done = 1'b0;
        si_sum   = 3'({1'b0, r_si} + 3'd1);
        med      = '0;
        prod     = '0;
        res      = '0;
        res.busy_res = 1'b1;

        case (r_phase)
            PH_IDLE: begin
                res.busy_res = 1'b0;
                if (i_in.start_request) begin
                    res.busy_res = 1'b1;
                    n_si    = 2'd0;
                    n_tc    = '0;
                    n_phase = (i_cfg.trigger_low_us == 8'd0) ? PH_THIGH : PH_TLOW;
                end
            end
            PH_TLOW: begin
                bumped = bump(r_tc);
                if (bumped >= lim({8'd0, i_cfg.trigger_low_us})) begin
                    n_tc    = '0;
                    n_phase = PH_THIGH;
                end else begin
                    n_tc = bumped;
                end
            end
            PH_THIGH: begin
                res.trigger_level = 1'b1;
                bumped = bump(r_tc);
                if (bumped >= lim({8'd0, i_cfg.trigger_high_us})) begin
                    n_tc    = '0;
                    n_phase = PH_WAIT;
                end else begin
                    n_tc = bumped;
                end
            end
            PH_WAIT: begin
                if (i_in.echo_level) begin
                    n_tc    = CW'(1);
                    n_phase = PH_ECHO;
                    if (CW'(1) >= lim_to) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, {US_W{1'b0}}};
                    end
                end else begin
                    bumped = bump(r_tc);
                    n_tc   = bumped;
                    if (bumped >= lim_to) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, {US_W{1'b0}}};
                    end
                end
            end
            PH_ECHO: begin
                if (i_in.echo_level) begin
                    bumped = bump(r_tc);
                    n_tc   = bumped;
                    if (bumped >= lim_to) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, {US_W{1'b0}}};
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_data = {1'b0, US_W'(r_tc)};
                end
            end
            default: begin
                n_phase = PH_GAP;
            end
        endcase

        // Store a finished sample and go to the gap
        if (wr_en) begin
            n_tc    = '0;
            n_phase = PH_GAP;
        end

        // Forward the sample written this tick to the median
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            view[i] = (wr_en && (wr_idx == 2'(i))) ? wr_data : r_samples[i];
        end

        // Count the gap; on its end start the next cycle or report
        if (n_phase == PH_GAP) begin
            if (i_cfg.sample_gap_us == 16'd0) begin
                gap_done = 1'b1;
            end else begin
                n_tc     = bump(n_tc);
                gap_done = (n_tc >= lim(i_cfg.sample_gap_us));
            end
            if (gap_done) begin
                n_tc = '0;
                if (si_sum >= 3'd3) begin
                    med  = median3(view[0], view[1], view[2]);
                    res.result_valid = 1'b1;
                    if (!med[US_W]) begin
                        prod = PROD_W'(med[US_W-1:0]) * PROD_W'(MM_SCALE);
                        res.echo_found     = 1'b1;
                        res.median_echo_us = med[US_W-1:0];
                        res.distance_mm    = prod[PROD_W-1:US_W];
                    end
                    n_si    = 2'd0;
                    n_phase = PH_IDLE;
                end else begin
                    n_si    = si_sum[1:0];
                    n_phase = (i_cfg.trigger_low_us == 8'd0) ? PH_THIGH : PH_TLOW;
                end
            end
        end
    end

    // Advance the control state on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tc    <= '0;
            r_si    <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tc    <= n_tc;
            r_si    <= n_si;
        end
    end

    // Sample store, written once per ranging cycle
    always_ff @(posedge i_clk) begin
        if (i_step && wr_en) begin
            r_samples[wr_idx] <= wr_data;
        end
    end

    assign o_res = res;

endmodule

// ===== sv/ultrasonic_range_median3.sv =====
// Top level of the median-of-three ultrasonic ranger.
// Input register, sequencer and result register. Depends on urm_pkg, urm_cfg, urm_ctrl.
//
// Usage:
//  Each input request is one microsecond tick: the sampled echo pin level and a
//  start flag. Every request yields exactly one result request carrying the
//  trigger drive, busy flag and, on the report tick, the median echo width in
//  microseconds and the distance in millimetres.
//  Channels use valid/stall; a request moves when valid is high and stall low.
//  A request passes the input register, then the result register. One request is
//  accepted every cycle unless the receiver stalls; the step logic between the two
//  registers is a combinational pass over the phase counter and three-sample store.
//  When the receiver stalls, the result register holds, the input register
//  fills, and then o_in_stall rises; no request is lost or repeated.
//  Config writes land at once and are meant for idle periods.
//  Reset (i_rst_n low, synchronous) empties both registers, sets the phase to
//  idle, and loads the register defaults 2, 12, 30000 and 10000.
module ultrasonic_range_median3 #(
    parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  urm_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output urm_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [urm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [urm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import urm_pkg::*;

    logic  r_in_valid;
    t_in   r_in_data;
    logic  r_out_valid;
    t_out  r_out_data;
    logic  advance;
    logic  in_take;
    t_cfg  cfg;
    t_out  res;

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    urm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    urm_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance && r_in_valid),
        .i_in    (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Hold the accepted request until the step logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // Advance the result register unless the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for ultrasonic_range_median3: a directed table of ticks, one measurement with the
// upper register bytes set and the longest timeout, then random measurements under several
// settings and idling patterns. Depends on urm_pkg and the ranger RTL; checked in-bench.
module tb;
    import urm_pkg::*;

    localparam int          COUNT_W  = COUNT_WIDTH_DEF;
    localparam int unsigned CNT_MAX  = (32'd1 << COUNT_W) - 1;
    localparam logic [16:0] NO_ECHO  = 17'h10000;
    localparam int unsigned MM_Q16   = 11141;
    localparam int          SETTLE   = 4;
    localparam int          RND_SETS = 8;
    localparam int          RND_REQS = 64;
    localparam int          DIR_N    = 24;

    typedef struct packed {
        logic echo;
        logic start;
        logic typed;
        t_out want;
    } t_step_row;

    localparam t_out QUIET     = '0;
    localparam t_out BUSY_ONLY = '{1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 14'd0};
    localparam t_out TRIG_ON   = '{1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 14'd0};
    localparam t_out NO_ECHO_R = '{1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 14'd0};

    // Settings for this table: trigger low 0, trigger high 0, timeout 2, gap 0
    localparam t_step_row DIR_TAB [DIR_N] = '{
        '{1'b0, 1'b0, 1'b1, QUIET},       // idle, nothing asked
        '{1'b1, 1'b0, 1'b1, QUIET},       // echo while idle is ignored
        '{1'b0, 1'b1, 1'b1, BUSY_ONLY},   // start tick only arms the cycle
        '{1'b0, 1'b0, 1'b1, TRIG_ON},     // zero trigger high acts as one tick
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},       // echo held to timeout: infinite
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b0, QUIET},       // start while busy is ignored
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b1, NO_ECHO_R},   // wait timeout, median infinite
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in                    i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out                   o_out_data;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    ultrasonic_range_median3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Ranger model state
    t_cfg        cfg_shadow;
    t_phase      ph;
    int unsigned tick_cnt;
    int unsigned shot_idx;
    logic [16:0] widths [3];

    // Echo pulse plan for the random ticks
    int unsigned wait_plan;
    int unsigned width_plan;
    logic        noisy;

    t_out pending_ticks [$];
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   mismatches;
    int   checked;
    int   sent;
    int   reports;
    int   echo_reports;
    int   settings;

    function automatic int unsigned clamp_limit(input int unsigned v);
        if (v < 1) return 1;
        if (v > CNT_MAX) return CNT_MAX;
        return v;
    endfunction

    function automatic void count_up();
        if (tick_cnt < CNT_MAX) tick_cnt++;
    endfunction

    function automatic void begin_shot();
        tick_cnt = 0;
        ph = (cfg_shadow.trigger_low_us == 8'd0) ? PH_THIGH : PH_TLOW;
    endfunction

    function automatic void close_shot(input logic [16:0] w);
        widths[(shot_idx < 3) ? shot_idx : 0] = w;
        tick_cnt = 0;
        ph = PH_GAP;
    endfunction

    // Middle value by a three-compare sort
    function automatic logic [16:0] middle_of(input logic [16:0] a, input logic [16:0] b,
                                              input logic [16:0] c);
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic [16:0] t;
        x = a;
        y = b;
        z = c;
        if (x > y) begin
            t = x; x = y; y = t;
        end
        if (y > z) begin
            t = y; y = z; z = t;
        end
        if (x > y) begin
            t = x; x = y; y = t;
        end
        return y;
    endfunction

    // Advance the model by one tick and return what the block reports for it
    function automatic t_out ranger_step(input t_in req);
        t_out        res;
        logic        gap_done;
        logic [16:0] med;
        int unsigned tmo;
        res = '0;
        res.busy_res = 1'b1;
        tmo = clamp_limit(32'(cfg_shadow.echo_timeout_us));
        case (ph)
            PH_IDLE: begin
                res.busy_res = 1'b0;
                if (req.start_request) begin
                    res.busy_res = 1'b1;
                    shot_idx = 0;
                    begin_shot();
                end
            end
            PH_TLOW: begin
                count_up();
                if (tick_cnt >= clamp_limit(32'(cfg_shadow.trigger_low_us))) begin
                    tick_cnt = 0;
                    ph = PH_THIGH;
                end
            end
            PH_THIGH: begin
                res.trigger_level = 1'b1;
                count_up();
                if (tick_cnt >= clamp_limit(32'(cfg_shadow.trigger_high_us))) begin
                    tick_cnt = 0;
                    ph = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (req.echo_level) begin
                    tick_cnt = 1;
                    ph = PH_ECHO;
                end else begin
                    count_up();
                end
                if (tick_cnt >= tmo) close_shot(NO_ECHO);
            end
            PH_ECHO: begin
                if (req.echo_level) begin
                    count_up();
                    if (tick_cnt >= tmo) close_shot(NO_ECHO);
                end else begin
                    close_shot({1'b0, tick_cnt[15:0]});
                end
            end
            default: ph = PH_GAP;
        endcase

        // Gap after each cycle; the third one ends with the report
        if (ph == PH_GAP) begin
            if (cfg_shadow.sample_gap_us == 16'd0) begin
                gap_done = 1'b1;
            end else begin
                count_up();
                gap_done = (tick_cnt >= clamp_limit(32'(cfg_shadow.sample_gap_us)));
            end
            if (gap_done) begin
                shot_idx++;
                if (shot_idx >= 3) begin
                    med = middle_of(widths[0], widths[1], widths[2]);
                    res.result_valid = 1'b1;
                    reports++;
                    if (!med[16]) begin
                        res.echo_found     = 1'b1;
                        res.median_echo_us = med[15:0];
                        res.distance_mm    = 14'((32'(med[15:0]) * MM_Q16) >> 16);
                        echo_reports++;
                    end
                    shot_idx = 0;
                    tick_cnt = 0;
                    ph = PH_IDLE;
                end else begin
                    begin_shot();
                end
            end
        end
        return res;
    endfunction

    // Next random tick: echo pulses timed against the model's phase, some noise
    function automatic t_in next_tick();
        t_in         req;
        int unsigned tmo;
        tmo = clamp_limit(32'(cfg_shadow.echo_timeout_us));
        if (ph == PH_IDLE) req.start_request = ($urandom_range(0, 3) == 0);
        else req.start_request = ($urandom_range(0, 19) == 0);
        if (noisy) begin
            req.echo_level = 1'($urandom_range(0, 1));
        end else begin
            case (ph)
                PH_WAIT: req.echo_level = (tick_cnt >= wait_plan);
                PH_ECHO: req.echo_level = (tick_cnt < width_plan);
                default: req.echo_level = ($urandom_range(0, 9) == 0);
            endcase
        end
        if (ph != PH_WAIT && ph != PH_ECHO) begin
            noisy      = ($urandom_range(0, 99) < 12);
            wait_plan  = $urandom_range(0, tmo);
            width_plan = $urandom_range(1, tmo + 1);
        end
        return req;
    endfunction

    function automatic void check_tick(input t_out want, input t_out got);
        if (got.trigger_level !== want.trigger_level) begin
            $error("trigger_level: expected %0d, got %0d", want.trigger_level, got.trigger_level);
            mismatches++;
        end
        if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            mismatches++;
        end
        if (got.result_valid !== want.result_valid) begin
            $error("result_valid: expected %0d, got %0d", want.result_valid, got.result_valid);
            mismatches++;
        end
        if (got.echo_found !== want.echo_found) begin
            $error("echo_found: expected %0d, got %0d", want.echo_found, got.echo_found);
            mismatches++;
        end
        if (got.median_echo_us !== want.median_echo_us) begin
            $error("median_echo_us: expected %0d, got %0d",
                   want.median_echo_us, got.median_echo_us);
            mismatches++;
        end
        if (got.distance_mm !== want.distance_mm) begin
            $error("distance_mm: expected %0d, got %0d", want.distance_mm, got.distance_mm);
            mismatches++;
        end
    endfunction

    // Check a result delivered at the clock edge, report whether the request was taken
    task automatic tick(output logic took);
        @(posedge i_clk);
        if (o_out_valid && !i_out_stall) begin
            if (pending_ticks.size() == 0) begin
                $error("result with nothing expected: %h", o_out_data);
                mismatches++;
            end else begin
                check_tick(pending_ticks.pop_front(), o_out_data);
                checked++;
            end
        end
        took = i_in_valid && !o_in_stall;
        i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    endtask

    // Hand one tick to the block; a typed expectation overrides the model's
    task automatic send_tick(input t_in req, input logic typed, input t_out typed_res);
        logic took;
        t_out res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            tick(took);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        took = 1'b0;
        while (!took) tick(took);
        res = ranger_step(req);
        pending_ticks.push_back(typed ? typed_res : res);
        sent++;
    endtask

    // Hold off the sender until every result is back, then let the pipe settle
    task automatic drain();
        logic took;
        i_in_valid <= 1'b0;
        while (pending_ticks.size() != 0) tick(took);
        repeat (SETTLE) tick(took);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic took;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        tick(took);
        case (idx)
            CFG_TRIGGER_LOW:  cfg_shadow.trigger_low_us  = val[7:0];
            CFG_TRIGGER_HIGH: cfg_shadow.trigger_high_us = val[7:0];
            CFG_ECHO_TIMEOUT: cfg_shadow.echo_timeout_us = val;
            default:          cfg_shadow.sample_gap_us   = val;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [15:0] tmo, input logic [15:0] gap);
        cfg_write(CFG_TRIGGER_LOW, lo);
        cfg_write(CFG_TRIGGER_HIGH, hi);
        cfg_write(CFG_ECHO_TIMEOUT, tmo);
        cfg_write(CFG_SAMPLE_GAP, gap);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // Longest timeout: two longer echoes and a short one, echo rising at once
    task automatic run_longest();
        t_in req;
        int  first;
        first = reports;
        req = '0;
        req.start_request = 1'b1;
        send_tick(req, 1'b0, QUIET);
        req.start_request = 1'b0;
        while (reports == first) begin
            case (ph)
                PH_WAIT: req.echo_level = 1'b1;
                PH_ECHO: req.echo_level = (tick_cnt < ((shot_idx < 2) ? 40 : 5));
                default: req.echo_level = 1'b0;
            endcase
            send_tick(req, 1'b0, QUIET);
        end
    endtask

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(64'd30_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_in req;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_TRIGGER_LOW;
        i_cfg_data  <= '0;
        cfg_shadow  = '{TRIGGER_LOW_RST, TRIGGER_HIGH_RST, ECHO_TIMEOUT_RST, SAMPLE_GAP_RST};
        ph          = PH_IDLE;
        tick_cnt    = 0;
        shot_idx    = 0;
        widths[0]   = '0;
        widths[1]   = '0;
        widths[2]   = '0;
        noisy       = 1'b0;
        wait_plan   = 0;
        width_plan  = 1;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        mismatches  = 0;
        checked     = 0;
        sent        = 0;
        reports     = 0;
        echo_reports = 0;
        settings    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table with zero trigger widths, short timeout and no gap
        load_settings(16'd0, 16'd0, 16'd2, 16'd0);
        for (int i = 0; i < DIR_N; i++) begin
            req.echo_level    = DIR_TAB[i].echo;
            req.start_request = DIR_TAB[i].start;
            send_tick(req, DIR_TAB[i].typed, DIR_TAB[i].want);
        end
        drain();

        // 8-bit registers written with the upper byte set to check that it drops
        load_settings(16'hFF02, 16'hFF03, 16'hFFFF, 16'd4);
        run_longest();

        // Random measurements, rotating through idling patterns
        for (int p = 0; p < RND_SETS; p++) begin
            drain();
            case (p % 4)
                0: begin
                    tx_idle_pct = 0;  rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 53; rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;  rx_stall_pct = 53;
                end
                default: begin
                    tx_idle_pct = 22; rx_stall_pct = 22;
                end
            endcase
            if (p == 0) begin
                load_settings(16'd0, 16'd1, 16'd1, 16'd0);
            end else if (p == 4) begin
                load_settings(16'd1, 16'd1, 16'd0, 16'd1);
            end else begin
                load_settings({8'($urandom), 8'($urandom_range(0, 4))},
                              {8'($urandom), 8'($urandom_range(0, 4))},
                              16'($urandom_range(1, 14)), 16'($urandom_range(0, 6)));
            end
            for (int n = 0; n < RND_REQS; n++) begin
                if (p == 5 && n == RND_REQS / 2) drain();
                send_tick(next_tick(), 1'b0, QUIET);
            end
        end
        drain();

        $display("Checked %0d tick results from %0d requests over %0d register settings,",
                 checked, sent, settings);
        $display("including %0d range reports, %0d of them with an echo.",
                 reports, echo_reports);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/urm_pkg.sv
sv/urm_cfg.sv
sv/urm_ctrl.sv
sv/ultrasonic_range_median3.sv
tb/tb.sv
